FILE: src/scsa_pkg.sv
// shared types and constants of the size-class slab allocator
`default_nettype none
package scsa_pkg;
	localparam int PAGE_BYTES      = 4096;
	localparam int POOL_PAGES      = 64;
	localparam int MIN_BLOCK_BYTES = 8;
	localparam int NUM_CLASSES     = 10;

	localparam int SLOTS_PER_PAGE = PAGE_BYTES / MIN_BLOCK_BYTES;
	localparam int SLOTS          = POOL_PAGES * SLOTS_PER_PAGE;
	localparam int OFF_W          = $clog2(PAGE_BYTES);
	localparam int MIN_W          = $clog2(MIN_BLOCK_BYTES);
	localparam int PG_W           = $clog2(POOL_PAGES);
	localparam int KS_W           = $clog2(SLOTS_PER_PAGE);
	localparam int SLOT_W         = PG_W + KS_W;
	localparam int LINK_W         = SLOT_W + 1;
	localparam int PLINK_W        = PG_W + 1;
	localparam int CLS_W          = $clog2(NUM_CLASSES);
	localparam int ADDR_W         = 18;
	localparam int SIZE_W         = 16;
	localparam int USE_W          = 10;

	localparam logic [LINK_W-1:0]  SLOT_NONE = LINK_W'(SLOTS);
	localparam logic [PLINK_W-1:0] PAGE_NONE = PLINK_W'(POOL_PAGES);

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [1:0] ST_BAD_FREE  = 2'd3;

	typedef struct packed {
		logic       accept;
		logic       dec;
		logic       pop_rd;
		logic       pop_wr;
		logic       carve_rd;
		logic       carve_nx;
		logic       carve_wr;
		logic       fchk;
		logic       flink;
		logic       rel_init;
		logic       rel_wr;
		logic       rel_end;
		logic       set_rsv;
		logic       fin;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic size_err;
		logic head_ok;
		logic fph_ok;
		logic pg_assigned;
		logic free_err;
		logic newuse_zero;
		logic rsv_ok;
		logic k_last;
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

FILE: src/scsa_ram.sv
// generic one-write one-read memory with registered read data
`default_nettype none
module scsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: src/scsa_dp.sv
// allocator datapath: link memories, page tables, class heads, result register
`default_nettype none
module scsa_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire scsa_pkg::cmd_t      cmd,
	output scsa_pkg::sts_t           sts,
	input  wire logic                in_op,
	input  wire logic [15:0]         in_size,
	input  wire logic [17:0]         in_addr,
	output logic                     out_valid,
	output logic [17:0]              out_addr,
	output logic [1:0]               out_status,
	input  wire logic                out_ready
);
	localparam int LW  = scsa_pkg::LINK_W;
	localparam int SW  = scsa_pkg::SLOT_W;
	localparam int PW  = scsa_pkg::PG_W;
	localparam int PLW = scsa_pkg::PLINK_W;
	localparam int KW  = scsa_pkg::KS_W;
	localparam int CW  = scsa_pkg::CLS_W;
	localparam int UW  = scsa_pkg::USE_W;
	localparam int NC  = scsa_pkg::NUM_CLASSES;
	localparam int NP  = scsa_pkg::POOL_PAGES;
	localparam int OW  = scsa_pkg::OFF_W;
	localparam int MW  = scsa_pkg::MIN_W;

	logic          op_q;
	logic [15:0]   size_q;
	logic [17:0]   addr_q;
	logic [CW-1:0] cls_q;
	logic [PW-1:0] pg_q;
	logic [SW-1:0] s_q;
	logic [LW-1:0] hd_q;
	logic [UW-1:0] newuse_q;
	logic [KW-1:0] k_q;
	logic [PLW-1:0] fph_q;
	logic [LW-1:0] head_q [NC];
	logic [PLW-1:0] rsv_q [NC];
	logic [NP-1:0] assigned_q;
	logic [NP-1:0] pnext_wr_q;
	logic          pnv_q;
	logic          out_valid_q;
	logic [17:0]   out_addr_q;
	logic [1:0]    out_st_q;

	logic [LW-1:0] sn_rd, sp_rd;
	logic [UW-1:0] use_rd;
	logic [CW-1:0] cls_rd;
	logic [PLW-1:0] pn_rd;

	logic           sn_we, sp_we, use_we, cls_we, pn_we;
	logic [SW-1:0]  sn_wa, sp_wa, sn_ra;
	logic [LW-1:0]  sn_wd, sp_wd;
	logic [PW-1:0]  use_wa, use_ra;
	logic [UW-1:0]  use_wd;

	logic [PW-1:0] pg_free;
	logic [SW-1:0] s_free;
	logic [LW-1:0] head_cur;
	logic [KW-1:0] kofs, stride;
	logic [SW-1:0] sk, sk_prev, sk_next;
	logic [CW-1:0] cidx;
	logic [LW-1:0] hd_free;
	logic [OW-1:0] off_mask;
	logic [16:0]   size_eff;
	logic [CW-1:0] cls_c;
	logic          size_err;
	logic [PLW-1:0] nxt;
	logic [LW-1:0] nx_fix;
	logic          nx_ok, pv_ok;

	assign pg_free  = addr_q[17:OW];
	assign s_free   = addr_q[17:MW];
	assign head_cur = head_q[cls_q];
	assign stride   = KW'(1) << cls_q;
	assign kofs     = k_q << cls_q;
	assign sk       = {pg_q, kofs};
	assign sk_prev  = {pg_q, KW'(kofs - stride)};
	assign sk_next  = {pg_q, KW'(kofs + stride)};
	assign cidx     = (cls_rd < CW'(NC)) ? cls_rd : '0;
	assign hd_free  = head_q[cidx];
	assign off_mask = OW'((13'(scsa_pkg::MIN_BLOCK_BYTES) << cls_rd) - 13'd1);
	assign nxt      = pnv_q ? pn_rd : PLW'({1'b0, pg_q} + 7'd1);
	assign nx_ok    = !sn_rd[LW-1];
	assign pv_ok    = !sp_rd[LW-1];
	assign nx_fix   = nx_ok ? sn_rd : scsa_pkg::SLOT_NONE;

	always_comb begin
		size_eff = (size_q == 16'd0) ? 17'd1 : {1'b0, size_q};
		cls_c    = CW'(NC - 1);
		for (int i = NC - 1; i >= 0; i--) begin
			if ((32'(scsa_pkg::MIN_BLOCK_BYTES) << i) >= 32'(size_eff)) begin
				cls_c = CW'(i);
			end
		end
		size_err = (32'(size_eff) > 32'(scsa_pkg::PAGE_BYTES)) ||
			((32'(scsa_pkg::MIN_BLOCK_BYTES) << (NC - 1)) < 32'(size_eff));
	end

	always_comb begin
		sn_we = 1'b0; sn_wa = sk; sn_wd = scsa_pkg::SLOT_NONE;
		sp_we = 1'b0; sp_wa = sk; sp_wd = scsa_pkg::SLOT_NONE;
		use_we = 1'b0; use_wa = pg_q; use_wd = '0;
		if (cmd.carve_wr) begin
			sn_we = 1'b1;
			sn_wd = sts.k_last ? scsa_pkg::SLOT_NONE : {1'b0, sk_next};
			sp_we = 1'b1;
			sp_wd = (k_q == '0) ? scsa_pkg::SLOT_NONE : {1'b0, sk_prev};
		end
		if (cmd.carve_nx) begin
			use_we = 1'b1;
		end
		if (cmd.pop_wr) begin
			sp_we  = nx_ok;
			sp_wa  = sn_rd[SW-1:0];
			use_we = 1'b1;
			use_wa = s_q[SW-1:KW];
			use_wd = use_rd + UW'(1);
		end
		if (cmd.fchk) begin
			sn_we  = 1'b1;
			sn_wa  = s_free;
			sn_wd  = hd_free[LW-1] ? scsa_pkg::SLOT_NONE : hd_free;
			sp_we  = 1'b1;
			sp_wa  = s_free;
			use_we = 1'b1;
			use_wa = pg_free;
			use_wd = use_rd - UW'(1);
		end
		if (cmd.flink) begin
			sp_we = !hd_q[LW-1];
			sp_wa = hd_q[SW-1:0];
			sp_wd = {1'b0, s_free};
		end
		if (cmd.rel_wr) begin
			sn_we = pv_ok;
			sn_wa = sp_rd[SW-1:0];
			sn_wd = nx_fix;
			sp_we = nx_ok;
			sp_wa = sn_rd[SW-1:0];
			sp_wd = pv_ok ? sp_rd : scsa_pkg::SLOT_NONE;
		end
	end

	assign sn_ra  = cmd.pop_rd ? head_cur[SW-1:0] : sk;
	assign use_ra = cmd.pop_rd ? head_cur[SW-1:KW] : pg_free;
	assign cls_we = cmd.carve_nx;
	assign pn_we  = cmd.rel_end;

	scsa_ram #(.WIDTH(LW), .DEPTH(scsa_pkg::SLOTS)) u_slot_next (
		.clk(clk), .we(sn_we), .waddr(sn_wa), .wdata(sn_wd), .raddr(sn_ra), .rdata(sn_rd)
	);
	scsa_ram #(.WIDTH(LW), .DEPTH(scsa_pkg::SLOTS)) u_slot_prev (
		.clk(clk), .we(sp_we), .waddr(sp_wa), .wdata(sp_wd), .raddr(sk), .rdata(sp_rd)
	);
	scsa_ram #(.WIDTH(UW), .DEPTH(NP)) u_page_use (
		.clk(clk), .we(use_we), .waddr(use_wa), .wdata(use_wd), .raddr(use_ra),
		.rdata(use_rd)
	);
	scsa_ram #(.WIDTH(CW), .DEPTH(NP)) u_page_class (
		.clk(clk), .we(cls_we), .waddr(pg_q), .wdata(cls_q), .raddr(pg_free),
		.rdata(cls_rd)
	);
	scsa_ram #(.WIDTH(PLW), .DEPTH(NP)) u_page_next (
		.clk(clk), .we(pn_we), .waddr(pg_q), .wdata(fph_q), .raddr(fph_q[PW-1:0]),
		.rdata(pn_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= in_op;
			size_q <= in_size;
			addr_q <= in_addr;
		end
		if (cmd.dec) begin
			cls_q <= cls_c;
		end
		if (cmd.pop_rd) begin
			s_q <= head_cur[SW-1:0];
		end
		if (cmd.carve_rd) begin
			pg_q <= fph_q[PW-1:0];
		end
		pnv_q <= pnext_wr_q[fph_q[PW-1:0]];
		if (cmd.carve_nx || cmd.rel_init) begin
			k_q <= '0;
		end else if (cmd.carve_wr || cmd.rel_wr) begin
			k_q <= k_q + KW'(1);
		end
		if (cmd.fchk) begin
			cls_q    <= cls_rd;
			hd_q     <= hd_free;
			newuse_q <= use_rd - UW'(1);
		end
		if (cmd.rel_init) begin
			pg_q <= rsv_q[cls_q][PW-1:0];
		end
		if (cmd.fin) begin
			out_addr_q <= (op_q == 1'b0 && cmd.code == scsa_pkg::ST_OK) ? {s_q, 3'b000} : '0;
			out_st_q   <= cmd.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NC; i++) begin
				head_q[i] <= scsa_pkg::SLOT_NONE;
				rsv_q[i]  <= scsa_pkg::PAGE_NONE;
			end
			assigned_q  <= '0;
			pnext_wr_q  <= '0;
			fph_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.pop_wr) begin
				head_q[cls_q] <= nx_fix;
				if (rsv_q[cls_q] == {1'b0, s_q[SW-1:KW]}) begin
					rsv_q[cls_q] <= scsa_pkg::PAGE_NONE;
				end
			end
			if (cmd.carve_nx) begin
				fph_q            <= nxt[PLW-1] ? scsa_pkg::PAGE_NONE : nxt;
				assigned_q[pg_q] <= 1'b1;
				rsv_q[cls_q]     <= {1'b0, pg_q};
				head_q[cls_q]    <= {1'b0, pg_q, KW'(0)};
			end
			if (cmd.fchk) begin
				head_q[cidx] <= {1'b0, s_free};
			end
			if (cmd.rel_init) begin
				rsv_q[cls_q] <= scsa_pkg::PAGE_NONE;
			end
			if (cmd.rel_wr && !pv_ok) begin
				head_q[cls_q] <= nx_fix;
			end
			if (cmd.rel_end) begin
				pnext_wr_q[pg_q] <= 1'b1;
				fph_q            <= {1'b0, pg_q};
				assigned_q[pg_q] <= 1'b0;
				rsv_q[cls_q]     <= {1'b0, pg_free};
			end
			if (cmd.set_rsv) begin
				rsv_q[cls_q] <= {1'b0, pg_free};
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.op          = op_q;
	assign sts.size_err    = size_err;
	assign sts.head_ok     = !head_cur[LW-1];
	assign sts.fph_ok      = !fph_q[PLW-1];
	assign sts.pg_assigned = assigned_q[pg_free];
	assign sts.free_err    = (cls_rd >= CW'(NC)) || ((addr_q[OW-1:0] & off_mask) != '0) ||
		(use_rd == '0);
	assign sts.newuse_zero = (newuse_q == '0);
	assign sts.rsv_ok      = !rsv_q[cls_q][PLW-1];
	assign sts.k_last      = (k_q == KW'((scsa_pkg::SLOTS_PER_PAGE >> cls_q) - 1));
	assign sts.out_free    = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_addr   = out_addr_q;
	assign out_status = out_st_q;
endmodule
`default_nettype wire

FILE: src/scsa_ctrl.sv
// allocator sequencer state machine
`default_nettype none
module scsa_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire scsa_pkg::sts_t sts,
	output scsa_pkg::cmd_t      cmd
);
	localparam logic [3:0] IDLE     = 4'd0;
	localparam logic [3:0] DEC      = 4'd1;
	localparam logic [3:0] ACHK     = 4'd2;
	localparam logic [3:0] POP_RD   = 4'd3;
	localparam logic [3:0] POP_WR   = 4'd4;
	localparam logic [3:0] CARVE_RD = 4'd5;
	localparam logic [3:0] CARVE_NX = 4'd6;
	localparam logic [3:0] CARVE_WR = 4'd7;
	localparam logic [3:0] FCHK     = 4'd8;
	localparam logic [3:0] FLINK    = 4'd9;
	localparam logic [3:0] REL_RD   = 4'd10;
	localparam logic [3:0] REL_WR   = 4'd11;
	localparam logic [3:0] REL_END  = 4'd12;
	localparam logic [3:0] FIN      = 4'd13;

	logic [3:0] state_q, state_d;
	logic [1:0] code_q, code_d;

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd      = '0;
		cmd.code = code_q;
		state_d  = state_q;
		code_d   = code_q;
		case (state_q)
			IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = DEC;
				end
			end
			DEC: begin
				if (!sts.op) begin
					if (sts.size_err) begin
						code_d  = scsa_pkg::ST_TOO_LARGE;
						state_d = FIN;
					end else begin
						cmd.dec = 1'b1;
						state_d = ACHK;
					end
				end else if (!sts.pg_assigned) begin
					code_d  = scsa_pkg::ST_BAD_FREE;
					state_d = FIN;
				end else begin
					state_d = FCHK;
				end
			end
			ACHK: begin
				if (sts.head_ok) begin
					state_d = POP_RD;
				end else if (sts.fph_ok) begin
					state_d = CARVE_RD;
				end else begin
					code_d  = scsa_pkg::ST_EXHAUSTED;
					state_d = FIN;
				end
			end
			POP_RD: begin
				cmd.pop_rd = 1'b1;
				state_d    = POP_WR;
			end
			POP_WR: begin
				cmd.pop_wr = 1'b1;
				code_d     = scsa_pkg::ST_OK;
				state_d    = FIN;
			end
			CARVE_RD: begin
				cmd.carve_rd = 1'b1;
				state_d      = CARVE_NX;
			end
			CARVE_NX: begin
				cmd.carve_nx = 1'b1;
				state_d      = CARVE_WR;
			end
			CARVE_WR: begin
				cmd.carve_wr = 1'b1;
				if (sts.k_last) begin
					state_d = POP_RD;
				end
			end
			FCHK: begin
				if (sts.free_err) begin
					code_d  = scsa_pkg::ST_BAD_FREE;
					state_d = FIN;
				end else begin
					cmd.fchk = 1'b1;
					state_d  = FLINK;
				end
			end
			FLINK: begin
				cmd.flink = 1'b1;
				code_d    = scsa_pkg::ST_OK;
				state_d   = FIN;
				if (sts.newuse_zero) begin
					if (sts.rsv_ok) begin
						cmd.rel_init = 1'b1;
						state_d      = REL_RD;
					end else begin
						cmd.set_rsv = 1'b1;
					end
				end
			end
			REL_RD: begin
				state_d = REL_WR;
			end
			REL_WR: begin
				cmd.rel_wr = 1'b1;
				state_d    = sts.k_last ? REL_END : REL_RD;
			end
			REL_END: begin
				cmd.rel_end = 1'b1;
				state_d     = FIN;
			end
			FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			code_q  <= scsa_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	a_fin_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> sts.out_free) else $error("result loaded over an untaken result");
	a_carve_page: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CARVE_NX |-> sts.fph_ok) else $error("carve without a free page");
	a_pop_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == POP_WR |-> $past(state_q) == POP_RD) else $error("pop write without read");
	a_rel_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == REL_WR && sts.k_last) |=> state_q == REL_END)
		else $error("release walk did not finish");
endmodule
`default_nettype wire

FILE: src/size_class_slab_allocator_core.sv
// size-class slab allocator top level
// alloc from a nonempty class list pops its head; an empty list first carves a free page
// free: pushes the block on its class list; a reserve page returned to the pool is unlinked
// one request at a time; carving writes one link entry per cycle
// reset: asynchronous, clears class heads, reserves, page flags and chains the free pages
// link and page memories need no clearing pass; valid bits stand in for page chain reset
`default_nettype none
module size_class_slab_allocator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // request_size, block_address, zero pad
	input  wire logic        s_axis_tuser,  // opcode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [23:0] m_axis_tdata   // granted_address, status, zero pad
);
	scsa_pkg::cmd_t cmd;
	scsa_pkg::sts_t sts;
	logic [17:0]    out_addr;
	logic [1:0]     out_status;

	scsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.sts(sts), .cmd(cmd)
	);

	scsa_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_op(s_axis_tuser), .in_size(s_axis_tdata[15:0]), .in_addr(s_axis_tdata[33:16]),
		.out_valid(m_axis_tvalid), .out_addr(out_addr), .out_status(out_status),
		.out_ready(m_axis_tready)
	);

	assign m_axis_tdata = {4'd0, out_status, out_addr};
endmodule
`default_nettype wire

FILE: verif/scsa_checker.sv
// request/result monitor with its own allocator state and in-order result comparison
`default_nettype none
module scsa_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // request_size, block_address, zero pad
	input  wire logic        s_axis_tuser,  // opcode
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [23:0] m_axis_tdata,  // granted_address, status, zero pad
	output int               fails,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AW  = scsa_pkg::ADDR_W;
	localparam int SZW = scsa_pkg::SIZE_W;
	localparam int NSL = scsa_pkg::SLOTS;
	localparam int NPG = scsa_pkg::POOL_PAGES;
	localparam int NCL = scsa_pkg::NUM_CLASSES;
	localparam int SPP = scsa_pkg::SLOTS_PER_PAGE;
	localparam int PGB = scsa_pkg::PAGE_BYTES;
	localparam int MBB = scsa_pkg::MIN_BLOCK_BYTES;
	localparam int UW  = scsa_pkg::USE_W;

	typedef struct packed {
		logic [AW-1:0] granted;
		logic [1:0]    status;
	} grant_t;

	int unsigned blk_next [NSL];
	int unsigned blk_prev [NSL];
	int unsigned pg_cls [NPG];
	bit          pg_used [NPG];
	int unsigned pg_cnt [NPG];
	int unsigned pg_next [NPG];
	int unsigned pg_prev [NPG];
	int unsigned free_pg;
	int unsigned cls_head [NCL];
	int unsigned cls_rsv [NCL];
	grant_t      grants_due [$];

	initial begin
		for (int i = 0; i < NPG; i++) begin
			pg_used[i] = 0;
			pg_next[i] = i + 1;
			pg_prev[i] = (i == 0) ? NPG : i - 1;
		end
		free_pg = 0;
		for (int i = 0; i < NCL; i++) begin
			cls_head[i] = NSL;
			cls_rsv[i]  = NPG;
		end
		fails   = 0;
		pending = 0;
	end

	function automatic bit blk_ok(int unsigned s);
		return s < NSL;
	endfunction

	function automatic bit pg_ok(int unsigned p);
		return p < NPG;
	endfunction

	function automatic void carve(int unsigned c);
		int unsigned pg, nxt, stride, n, base, s;
		pg     = free_pg;
		nxt    = pg_next[pg];
		stride = 1 << c;
		n      = SPP >> c;
		base   = pg * SPP;
		free_pg = pg_ok(nxt) ? nxt : NPG;
		if (pg_ok(nxt))
			pg_prev[nxt] = NPG;
		for (int unsigned k = 0; k < n; k++) begin
			s = base + k * stride;
			blk_prev[s] = (k == 0) ? NSL : s - stride;
			blk_next[s] = (k + 1 < n) ? s + stride : NSL;
		end
		cls_head[c] = (n > 0) ? base : NSL;
		pg_cls[pg]  = c;
		pg_used[pg] = 1;
		pg_cnt[pg]  = 0;
		cls_rsv[c]  = pg;
	endfunction

	function automatic void return_reserve(int unsigned c);
		int unsigned pg, stride, n, base, s, nx, pv;
		pg     = cls_rsv[c];
		stride = 1 << c;
		n      = SPP >> c;
		if (!pg_ok(pg))
			return;
		cls_rsv[c] = NPG;
		base = pg * SPP;
		for (int unsigned k = 0; k < n; k++) begin
			s  = base + k * stride;
			nx = blk_next[s];
			pv = blk_prev[s];
			if (!blk_ok(nx))
				nx = NSL;
			if (blk_ok(pv))
				blk_next[pv] = nx;
			else
				cls_head[c] = nx;
			if (blk_ok(nx))
				blk_prev[nx] = blk_ok(pv) ? pv : NSL;
		end
		pg_prev[pg] = NPG;
		pg_next[pg] = free_pg;
		if (pg_ok(free_pg))
			pg_prev[free_pg] = pg;
		free_pg = pg;
		pg_used[pg] = 0;
	endfunction

	function automatic grant_t allocate(logic [SZW-1:0] size);
		grant_t      r;
		int unsigned sz, c, s, pg, nx;
		r  = '{granted: '0, status: scsa_pkg::ST_OK};
		sz = (size == 0) ? 1 : size;
		c  = 0;
		if (sz > PGB) begin
			r.status = scsa_pkg::ST_TOO_LARGE;
			return r;
		end
		while (c < NCL && (MBB << c) < sz)
			c++;
		if (c >= NCL) begin
			r.status = scsa_pkg::ST_TOO_LARGE;
			return r;
		end
		if (!blk_ok(cls_head[c])) begin
			if (!pg_ok(free_pg)) begin
				r.status = scsa_pkg::ST_EXHAUSTED;
				return r;
			end
			carve(c);
			if (!blk_ok(cls_head[c])) begin
				r.status = scsa_pkg::ST_EXHAUSTED;
				return r;
			end
		end
		s  = cls_head[c];
		pg = s / SPP;
		pg_cnt[pg] = (pg_cnt[pg] + 1) & ((1 << UW) - 1);
		if (cls_rsv[c] == pg)
			cls_rsv[c] = NPG;
		nx = blk_next[s];
		if (blk_ok(nx)) begin
			cls_head[c]  = nx;
			blk_prev[nx] = NSL;
		end else begin
			cls_head[c] = NSL;
		end
		r.granted = AW'(s * MBB);
		return r;
	endfunction

	function automatic grant_t release_block(logic [AW-1:0] addr);
		grant_t      r;
		int unsigned pg, c, off, s, hd;
		r = '{granted: '0, status: scsa_pkg::ST_BAD_FREE};
		if (addr >= NPG * PGB)
			return r;
		pg = addr / PGB;
		if (!pg_ok(pg) || !pg_used[pg])
			return r;
		c = pg_cls[pg];
		if (c >= NCL)
			return r;
		off = addr % PGB;
		if ((off & ((MBB << c) - 1)) != 0)
			return r;
		if (pg_cnt[pg] == 0)
			return r;
		s = addr / MBB;
		if (!blk_ok(s))
			return r;
		hd = cls_head[c];
		blk_prev[s] = NSL;
		blk_next[s] = blk_ok(hd) ? hd : NSL;
		if (blk_ok(hd))
			blk_prev[hd] = s;
		cls_head[c] = s;
		pg_cnt[pg] = (pg_cnt[pg] - 1) & ((1 << UW) - 1);
		if (pg_cnt[pg] == 0) begin
			if (pg_ok(cls_rsv[c]))
				return_reserve(c);
			cls_rsv[c] = pg;
		end
		r.status = scsa_pkg::ST_OK;
		return r;
	endfunction

	always @(posedge clk) begin
		grant_t want, got;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			if (s_axis_tuser)
				grants_due.push_back(release_block(s_axis_tdata[SZW +: AW]));
			else
				grants_due.push_back(allocate(s_axis_tdata[SZW-1:0]));
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.granted = m_axis_tdata[AW-1:0];
			got.status  = m_axis_tdata[AW +: 2];
			if (grants_due.size() == 0) begin
				$display("%0t: result with no request waiting: addr %h status %0d",
					$time, got.granted, got.status);
				fails++;
			end else begin
				want = grants_due.pop_front();
				if (want.granted != got.granted) begin
					$display("%0t: granted_address expected %h actual %h",
						$time, want.granted, got.granted);
					fails++;
				end
				if (want.status != got.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, got.status);
					fails++;
				end
			end
		end
		pending <= grants_due.size();
	end
endmodule
`default_nettype wire

FILE: verif/tb_size_class_slab_allocator_core.sv
// stimulus and verdict for the size-class slab allocator core
`default_nettype none
module tb_size_class_slab_allocator_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 3000000;
	localparam int AW    = scsa_pkg::ADDR_W;
	localparam int SZW   = scsa_pkg::SIZE_W;
	localparam int MBB   = scsa_pkg::MIN_BLOCK_BYTES;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [23:0] m_axis_tdata;
	int          fails, pending;
	int          idle_pct = 0, stall_pct = 0;
	bit          op_sent [$];
	logic [AW-1:0] live [$];
	logic [AW-1:0] freed [$];

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	size_class_slab_allocator_core dut (.*);

	scsa_checker chk (.*);

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		bit op;
		if (arst_n && m_axis_tvalid && m_axis_tready && op_sent.size() > 0) begin
			op = op_sent.pop_front();
			if (!op && m_axis_tdata[AW +: 2] == scsa_pkg::ST_OK)
				live.push_back(m_axis_tdata[AW-1:0]);
		end
	end

	task automatic send(bit op, logic [SZW-1:0] size, logic [AW-1:0] addr);
		bit rdy;
		if ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {6'd0, addr, size};
		op_sent.push_back(op);
		forever begin
			@(negedge clk);
			rdy = s_axis_tready;
			@(posedge clk);
			if (rdy)
				break;
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0 || op_sent.size() != 0)
			@(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	task automatic free_live(int pick);
		logic [AW-1:0] a;
		a = live[pick];
		live.delete(pick);
		freed.push_back(a);
		if (freed.size() > 8)
			void'(freed.pop_front());
		send(1, SZW'($urandom), a);
	endtask

	task automatic random_item();
		int r, c;
		r = $urandom_range(99);
		if (r < 50 || live.size() == 0) begin
			c = ($urandom_range(3) == 0) ? $urandom_range(9) : $urandom_range(4);
			send(0, SZW'((MBB << c) - $urandom_range((MBB << c) / 2)), AW'($urandom));
		end else if (r < 88) begin
			free_live($urandom_range(live.size() - 1));
		end else if (r < 93) begin
			send(0, SZW'($urandom), AW'($urandom));
		end else if (r < 98) begin
			send(1, SZW'($urandom), AW'($urandom));
		end else if (freed.size() > 0) begin
			send(1, SZW'($urandom), freed[$urandom_range(freed.size() - 1)]);
		end else begin
			send(1, SZW'($urandom), '1);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed corners
		send(1, 0, 0);
		send(0, 0, 0);
		send(0, 1, '1);
		send(0, 8, 0);
		send(0, 9, 0);
		send(0, 4096, 0);
		send(0, 4097, 0);
		send(0, 16'hffff, 0);
		send(1, 0, '1);
		send(1, 0, 18'h3f000);
		send(1, 0, 18'h00004);
		send(0, 2048, 0);
		send(0, 1025, 0);
		send(0, 17, 0);
		drain();
		while (live.size() > 0)
			free_live(live.size() - 1);
		drain();
		send(1, 0, 0);

		// run the pool dry with page-sized blocks
		repeat (66) send(0, 4096, 0);
		drain();
		while (live.size() > 0)
			free_live($urandom_range(live.size() - 1));
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 27 : 70) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 27 : 70) : 0;
			repeat (100) random_item();
			drain();
		end

		if (fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
src/scsa_pkg.sv
src/scsa_ram.sv
src/scsa_dp.sv
src/scsa_ctrl.sv
src/size_class_slab_allocator_core.sv
verif/scsa_checker.sv
verif/tb_size_class_slab_allocator_core.sv
